// ===== hdl/cc2l_pkg.sv =====
// ----------------------------------------------------------------------------
// cc2l_pkg: shared types and constants
// Scan modes, character codes and the result run record that passes from
// the classifier through the queue to the serialiser.
// ----------------------------------------------------------------------------
package cc2l_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // most text bytes a single item can produce
  localparam int unsigned MAX_BYTES = 4;
  localparam int unsigned CNT_W     = 3;

  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_SLASH    = 3'd1,
    MODE_IN_BLOCK = 3'd2,
    MODE_STAR     = 3'd3,
    MODE_CLOSED   = 3'd4,
    MODE_IN_LINE  = 3'd5
  } scan_mode_e;

  // results of one input item: n_bytes text bytes, then the end marker
  // when with_end is set
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          n_bytes;
    logic                      with_end;
  } burst_t;

endpackage

// ===== hdl/cc2l_front.sv =====
// ----------------------------------------------------------------------------
// cc2l_front: input classifier
// Holds the scan mode, takes one word per cycle while the queue is not full and
// turns it into a run of result bytes, pushed into the queue whenever the run is not empty.
// ----------------------------------------------------------------------------
module cc2l_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [7:0]        in_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output cc2l_pkg::burst_t  burst_o
);

  cc2l_pkg::scan_mode_e mode_q, mode_d;
  cc2l_pkg::burst_t     burst;
  logic                 accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign push_o     = accept & ((burst.n_bytes != '0) | burst.with_end);
  assign burst_o    = burst;

  always_comb begin
    mode_d         = mode_q;
    burst.bytes    = '0;
    burst.n_bytes  = '0;
    burst.with_end = 1'b0;
    if (operation_i == cc2l_pkg::OP_END) begin
      // flush whatever is held, then the marker
      burst.with_end = 1'b1;
      mode_d         = cc2l_pkg::MODE_NORMAL;
      case (mode_q)
        cc2l_pkg::MODE_SLASH: begin
          burst.bytes[0] = cc2l_pkg::CH_SLASH;
          burst.n_bytes  = 3'd1;
        end
        cc2l_pkg::MODE_STAR: begin
          burst.bytes[0] = cc2l_pkg::CH_STAR;
          burst.n_bytes  = 3'd1;
        end
        cc2l_pkg::MODE_CLOSED: begin
          burst.bytes[0] = cc2l_pkg::CH_NL;
          burst.n_bytes  = 3'd1;
        end
        default: begin
          burst.n_bytes = '0;
        end
      endcase
    end else begin
      case (mode_q)
        cc2l_pkg::MODE_SLASH: begin
          burst.bytes[0] = cc2l_pkg::CH_SLASH;
          burst.n_bytes  = 3'd2;
          if (in_byte_i == cc2l_pkg::CH_STAR) begin
            burst.bytes[1] = cc2l_pkg::CH_SLASH;
            mode_d         = cc2l_pkg::MODE_IN_BLOCK;
          end else if (in_byte_i == cc2l_pkg::CH_SLASH) begin
            burst.bytes[1] = cc2l_pkg::CH_SLASH;
            mode_d         = cc2l_pkg::MODE_IN_LINE;
          end else begin
            burst.bytes[1] = in_byte_i;
            mode_d         = cc2l_pkg::MODE_NORMAL;
          end
        end
        cc2l_pkg::MODE_IN_BLOCK: begin
          if (in_byte_i == cc2l_pkg::CH_STAR) begin
            mode_d = cc2l_pkg::MODE_STAR;
          end else if (in_byte_i == cc2l_pkg::CH_NL) begin
            burst.bytes[0] = cc2l_pkg::CH_NL;
            burst.bytes[1] = cc2l_pkg::CH_SLASH;
            burst.bytes[2] = cc2l_pkg::CH_SLASH;
            burst.n_bytes  = 3'd3;
          end else begin
            burst.bytes[0] = in_byte_i;
            burst.n_bytes  = 3'd1;
          end
        end
        cc2l_pkg::MODE_STAR: begin
          burst.bytes[0] = cc2l_pkg::CH_STAR;
          if (in_byte_i == cc2l_pkg::CH_SLASH) begin
            burst.n_bytes = '0;
            mode_d        = cc2l_pkg::MODE_CLOSED;
          end else if (in_byte_i == cc2l_pkg::CH_STAR) begin
            // keep holding the newest star
            burst.n_bytes = 3'd1;
          end else if (in_byte_i == cc2l_pkg::CH_NL) begin
            burst.bytes[1] = cc2l_pkg::CH_NL;
            burst.bytes[2] = cc2l_pkg::CH_SLASH;
            burst.bytes[3] = cc2l_pkg::CH_SLASH;
            burst.n_bytes  = 3'd4;
            mode_d         = cc2l_pkg::MODE_IN_BLOCK;
          end else begin
            burst.bytes[1] = in_byte_i;
            burst.n_bytes  = 3'd2;
            mode_d         = cc2l_pkg::MODE_IN_BLOCK;
          end
        end
        cc2l_pkg::MODE_CLOSED: begin
          // newline after the close, unless the source supplies one
          burst.bytes[0] = cc2l_pkg::CH_NL;
          burst.n_bytes  = 3'd1;
          if (in_byte_i == cc2l_pkg::CH_NL) begin
            mode_d = cc2l_pkg::MODE_NORMAL;
          end else if (in_byte_i == cc2l_pkg::CH_SLASH) begin
            mode_d = cc2l_pkg::MODE_SLASH;
          end else begin
            burst.bytes[1] = in_byte_i;
            burst.n_bytes  = 3'd2;
            mode_d         = cc2l_pkg::MODE_NORMAL;
          end
        end
        cc2l_pkg::MODE_IN_LINE: begin
          burst.bytes[0] = in_byte_i;
          burst.n_bytes  = 3'd1;
          if (in_byte_i == cc2l_pkg::CH_NL) begin
            mode_d = cc2l_pkg::MODE_NORMAL;
          end
        end
        default: begin
          if (in_byte_i == cc2l_pkg::CH_SLASH) begin
            mode_d = cc2l_pkg::MODE_SLASH;
          end else begin
            burst.bytes[0] = in_byte_i;
            burst.n_bytes  = 3'd1;
            mode_d         = cc2l_pkg::MODE_NORMAL;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cc2l_pkg::MODE_NORMAL;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

endmodule

// ===== hdl/cc2l_queue.sv =====
// ----------------------------------------------------------------------------
// cc2l_queue: run queue
// Small FIFO of result runs between the classifier and the serialiser.
// ----------------------------------------------------------------------------
module cc2l_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cc2l_pkg::burst_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              not_empty_o,
  output cc2l_pkg::burst_t  pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cc2l_pkg::burst_t mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o      = (count_q == CW'(DEPTH));
  assign not_empty_o = (count_q != '0);
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & not_empty_o;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/cc2l_back.sv =====
// ----------------------------------------------------------------------------
// cc2l_back: result serialiser
// Holds one run and hands out its results one word per cycle while the output
// is not stalled, marking the last one; loads the next run as the current one finishes.
// ----------------------------------------------------------------------------
module cc2l_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_not_empty_i,
  input  cc2l_pkg::burst_t  q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              has_byte_o,
  output logic              end_of_text_o,
  output logic              last_o
);

  cc2l_pkg::burst_t           cur_q;
  logic [1:0]                 pos_q;
  logic                       busy_q;
  logic [cc2l_pkg::CNT_W-1:0] total, pos_ext;
  logic                       take, done, load;

  assign total   = cur_q.n_bytes + cc2l_pkg::CNT_W'(cur_q.with_end);
  assign pos_ext = cc2l_pkg::CNT_W'(pos_q);

  assign has_byte_o    = (pos_ext < cur_q.n_bytes);
  assign out_byte_o    = has_byte_o ? cur_q.bytes[pos_q] : 8'h00;
  assign end_of_text_o = ~has_byte_o;
  assign last_o        = (pos_ext == total - 1'b1);
  assign out_valid_o   = busy_q;

  assign take  = busy_q & ~out_stall_i;
  assign done  = take & last_o;
  assign load  = q_not_empty_i & (~busy_q | done);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      pos_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (take) begin
      pos_q <= pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_data_i;
    end
  end

endmodule

// ===== hdl/c_comment_to_line_comment.sv =====
// ----------------------------------------------------------------------------
// c_comment_to_line_comment: block comment to line comment rewriter
// Streams source text and rewrites block comments as runs of line comments.
// ----------------------------------------------------------------------------
// One input word is taken per cycle while the run queue has room; each word
// yields zero to four result words, which leave at one per cycle while the
// output is not stalled, so the sustained rate is one input word per cycle
// on ordinary text and the output serialiser is the limit on longer runs. The
// classifier updates its scan mode in the cycle it takes a word; a result is
// registered in the run queue and then in the serialiser before it is output;
// a QUEUE_DEPTH-run queue lets each side stall without holding up the other.
module c_comment_to_line_comment #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       end_of_text_o,
  output logic       last_o
);

  cc2l_pkg::burst_t push_data, pop_data;
  logic             push, full, pop, not_empty;

  cc2l_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .in_byte_i   (in_byte_i),
    .q_full_i    (full),
    .push_o      (push),
    .burst_o     (push_data)
  );

  cc2l_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .pop_data_o  (pop_data)
  );

  cc2l_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (not_empty),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .has_byte_o    (has_byte_o),
    .end_of_text_o (end_of_text_o),
    .last_o        (last_o)
  );

endmodule

// ===== hdl/cc2l_checker.sv =====
// ----------------------------------------------------------------------------
// cc2l_checker: port-level checks
// Watches the top level's ports for output word consistency and stall hold.
// ----------------------------------------------------------------------------
module cc2l_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       has_byte_o,
  input logic       end_of_text_o,
  input logic       last_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(has_byte_o) && $stable(end_of_text_o) && $stable(last_o))
    else $error("stalled output word changed");

  // the end marker always closes its item's run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_text_o |-> last_o && !has_byte_o)
    else $error("end marker not last or carries a byte");

  // every word is either a byte or the end marker
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> has_byte_o != end_of_text_o)
    else $error("output word neither byte nor end marker");

  // a word without a byte shows zero
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> out_byte_o == 8'h00)
    else $error("byte field not zero on end marker");

endmodule

bind c_comment_to_line_comment cc2l_checker u_cc2l_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .has_byte_o    (has_byte_o),
  .end_of_text_o (end_of_text_o),
  .last_o        (last_o)
);
